// File: rtl/free_camera_pose_update_top_assert.svh
// assertion macros for the free camera pose update block
// used by free_camera_pose_update_top; clock clk_i and reset rst_ni are implied
`ifndef FREE_CAMERA_POSE_UPDATE_TOP_ASSERT_SVH
`define FREE_CAMERA_POSE_UPDATE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge out of reset
`define FCPU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fcpu assertion failed");
// condition implies consequence in the next cycle
`define FCPU_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("fcpu assertion failed");
`else
`define FCPU_ASSERT(lbl, prop)
`define FCPU_ASSERT_NEXT(lbl, cond, cons)
`endif

`endif

// File: rtl/fcpu_pkg.sv
// shared types, constants and table functions for the free camera pose update
// no dependencies
package fcpu_pkg;

  localparam int unsigned POS_FRAC_BITS_DEF = 16;
  localparam int unsigned TRIG_ITER_DEF     = 16;

  // angle units are 1/64 degree
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int PITCH_LIMIT  = 5696;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint GAIN_INV    = 64'sd652032874;
  // arctangent of one, a quarter of pi
  localparam longint ATAN_ONE    = PI_Q30 / 4;
  // remainder to radians: r*pi/11520 = r*Q + (r*R)/11520
  localparam int unsigned ZQ     = 292817;
  localparam int unsigned ZR     = 7586;
  // reciprocal of 45 for the /11520 = /256/45 split
  localparam int unsigned RECIP45 = 372828;

  // trig word, direction word widths
  localparam int unsigned TW = 34;
  localparam int unsigned FW = TW + 1;
  localparam int unsigned DW = FW + 1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_DIST = 2'd1;
  localparam logic [15:0] MOVE_STEP_RST = 16'd6554;
  localparam logic [7:0]  CURSOR_DIST_RST = 8'd10;

  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_PREP,
    TOP_ZMUL,
    TOP_ZDIV,
    TOP_ITER,
    TOP_FIN
  } trig_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ZMUL,
    S_ZDIV,
    S_ITER,
    S_FIN,
    S_FMUL0,
    S_FMUL2,
    S_MOVE,
    S_ROTATE,
    S_CURSOR,
    S_OUT
  } state_e;

  typedef struct packed {
    trig_op_e   top;
    logic       load;
    logic       fmul;
    logic       fsel;
    logic       move;
    logic       rotate;
    logic       cursor;
    logic       out_load;
    logic [1:0] axis;
  } dp_cmd_t;

  // quotient of a small non-negative numerator, restoring long division
  function automatic longint quot_f(input longint num, input longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 31; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      q   = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i in q30 radians, truncated alternating series
  function automatic logic [31:0] atan_q30_f(input int i);
    longint sum;
    longint t;
    int     e;
    sum = 0;
    if (i == 0) begin
      return 32'(ATAN_ONE);
    end
    for (int k = 0; k < 32; k++) begin
      e = 30 - i * (2 * k + 1);
      if (e >= 0) begin
        t = quot_f(longint'(1) << e, longint'(2 * k + 1));
        sum = ((k & 1) == 1) ? sum - t : sum + t;
      end
    end
    return 32'(sum);
  endfunction

endpackage

// File: rtl/fcpu_cordic.sv
// iterative cordic sine and cosine of an angle in 1/64 degree, q30 results
// depends on fcpu_pkg; stepped one operation per cycle by the controller
module fcpu_cordic import fcpu_pkg::*; #(
  parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                               clk_i,
  input  trig_op_e                           op_i,
  input  logic [$clog2(TRIG_ITERATIONS)-1:0] idx_i,
  input  logic signed [15:0]                 angle_i,
  output logic signed [TW-1:0]               sin_o,
  output logic signed [TW-1:0]               cos_o
);

  localparam int unsigned ZW = 34;

  logic [14:0]          a_n;
  logic [1:0]           quad_d, quad_q;
  logic [12:0]          rem_d, rem_q;
  logic [31:0]          pq_q;
  logic [25:0]          pr_q;
  logic [36:0]          dm;
  logic signed [ZW-1:0] z_init, z_d, z_q, atan_ext;
  logic signed [TW-1:0] x_d, x_q, y_d, y_q, x_sh, y_sh;
  logic signed [TW-1:0] sin_q, cos_q;
  logic [31:0]          atan_tab [TRIG_ITERATIONS];

  // arctangent table, constant per step
  for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_atan
    assign atan_tab[g] = atan_q30_f(g);
  end

  // quadrant and remainder of the wrapped angle
  always_comb begin
    if (angle_i < 0) begin
      a_n = 15'(angle_i + 16'sd23040);
    end else begin
      a_n = 15'(angle_i);
    end
    priority if (a_n >= 15'(3 * QUARTER_TURN)) begin
      quad_d = 2'd3;
      rem_d  = 13'(a_n - 15'(3 * QUARTER_TURN));
    end else if (a_n >= 15'(2 * QUARTER_TURN)) begin
      quad_d = 2'd2;
      rem_d  = 13'(a_n - 15'(2 * QUARTER_TURN));
    end else if (a_n >= 15'(QUARTER_TURN)) begin
      quad_d = 2'd1;
      rem_d  = 13'(a_n - 15'(QUARTER_TURN));
    end else begin
      quad_d = 2'd0;
      rem_d  = 13'(a_n);
    end
  end

  // rounded radians: whole part plus remainder over 11520 by reciprocal
  always_comb begin
    dm     = 37'(pr_q[25:8]) * 37'(RECIP45);
    z_init = $signed({2'b00, pq_q}) + $signed({21'b0, dm[36:24]});
  end

  // one rotation step
  always_comb begin
    x_sh     = x_q >>> idx_i;
    y_sh     = y_q >>> idx_i;
    atan_ext = $signed({2'b00, atan_tab[idx_i]});
    if (!z_q[ZW-1]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - atan_ext;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + atan_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      TOP_PREP: begin
        quad_q <= quad_d;
        rem_q  <= rem_d;
      end
      TOP_ZMUL: begin
        pq_q <= 32'(rem_q * 32'(ZQ));
        pr_q <= 26'(rem_q * 26'(ZR)) + 26'(QUARTER_TURN);
      end
      TOP_ZDIV: begin
        z_q <= z_init;
        x_q <= TW'(GAIN_INV);
        y_q <= '0;
      end
      TOP_ITER: begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
      end
      TOP_FIN: begin
        unique case (quad_q)
          2'd0: begin sin_q <= y_q;  cos_q <= x_q;  end
          2'd1: begin sin_q <= x_q;  cos_q <= -y_q; end
          2'd2: begin sin_q <= -y_q; cos_q <= -x_q; end
          default: begin sin_q <= -x_q; cos_q <= y_q; end
        endcase
      end
      default: ;
    endcase
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: rtl/fcpu_datapath.sv
// datapath: pose registers, configuration, two cordic units, move and cursor math
// depends on fcpu_pkg and fcpu_cordic; driven by fcpu_ctrl commands
module fcpu_datapath import fcpu_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS   = POS_FRAC_BITS_DEF,
  parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dp_cmd_t                            cmd_i,
  input  logic [$clog2(TRIG_ITERATIONS)-1:0] idx_i,
  input  logic                               cfg_we_i,
  input  logic [CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic                               key_forward_i,
  input  logic                               key_back_i,
  input  logic                               key_left_i,
  input  logic                               key_right_i,
  input  logic                               key_rise_i,
  input  logic                               key_sink_i,
  input  logic signed [10:0]                 turn_x_i,
  input  logic signed [10:0]                 turn_y_i,
  output logic signed [31:0]                 pos_x_o,
  output logic signed [31:0]                 pos_y_o,
  output logic signed [31:0]                 pos_z_o,
  output logic [14:0]                        yaw_angle_o,
  output logic signed [13:0]                 pitch_angle_o,
  output logic signed [15:0]                 cursor_x_o,
  output logic signed [15:0]                 cursor_y_o,
  output logic signed [15:0]                 cursor_z_o
);

  localparam int unsigned SH     = 46 - POS_FRAC_BITS;
  localparam int unsigned CUR_SH = 30 - POS_FRAC_BITS;
  localparam int unsigned PW     = DW + 17;
  localparam int unsigned MW     = PW + 1;
  localparam int unsigned NW     = 56;
  localparam logic signed [2*TW-1:0] F_HALF = (2*TW)'(1) << 29;
  localparam logic signed [PW-1:0]   M_HALF = PW'(1) << (SH - 1);
  localparam logic signed [DW-1:0]   ONE_Q30 = DW'(1) << 30;

  logic [15:0]          move_step_q;
  logic [7:0]           cursor_dist_q;
  logic signed [31:0]   cam_q [3];
  logic [14:0]          yaw_q;
  logic signed [13:0]   pitch_q;
  logic                 kf_q, kb_q, kl_q, kr_q, ku_q, ks_q;
  logic signed [10:0]   tx_q, ty_q;
  logic signed [FW-1:0] f0_q, f2_q;
  logic signed [15:0]   cur_q [3];
  logic signed [31:0]   out_pos_q [3];
  logic [14:0]          out_yaw_q;
  logic signed [13:0]   out_pitch_q;
  logic signed [15:0]   out_cur_q [3];

  logic signed [TW-1:0] sin_y, cos_y, sin_p, cos_p;
  logic signed [2*TW-1:0] fprod, fround;
  logic signed [FW-1:0] fnew;
  logic signed [DW-1:0] fa, ra, fterm, rterm, dvec;
  logic                 fpos, fneg, rpos, rneg;
  logic signed [PW-1:0] prod_m, mv;
  logic signed [MW-1:0] csum;
  logic signed [31:0]   cam_cur, cam_new;
  logic signed [NW-1:0] cprod, nsum, qt;
  logic signed [15:0]   cur_new;
  logic signed [18:0]   yv;
  logic signed [18:0]   yofs;
  logic [14:0]          yaw_new;
  logic signed [17:0]   pv;
  logic signed [13:0]   pitch_new;

  // trig units for yaw and pitch run side by side
  fcpu_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_yaw (
    .clk_i   (clk_i),
    .op_i    (cmd_i.top),
    .idx_i   (idx_i),
    .angle_i ($signed({1'b0, yaw_q})),
    .sin_o   (sin_y),
    .cos_o   (cos_y)
  );

  fcpu_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_pitch (
    .clk_i   (clk_i),
    .op_i    (cmd_i.top),
    .idx_i   (idx_i),
    .angle_i ({{2{pitch_q[13]}}, pitch_q}),
    .sin_o   (sin_p),
    .cos_o   (cos_p)
  );

  // front x and z: cos(pitch) times sin or cos of yaw, rounded, negated
  always_comb begin
    fprod  = (2*TW)'(cos_p) * (2*TW)'(cmd_i.fsel ? cos_y : sin_y);
    fround = (fprod + F_HALF) >>> 30;
    fnew   = -$signed(fround[FW-1:0]);
  end

  // per-axis direction terms
  always_comb begin
    cam_cur = cam_q[0];
    fpos    = kf_q & ~kb_q;
    fneg    = kb_q & ~kf_q;
    rpos    = kr_q & ~kl_q;
    rneg    = kl_q & ~kr_q;
    unique case (cmd_i.axis)
      2'd1: begin
        fa      = -DW'(sin_p);
        ra      = ONE_Q30;
        rpos    = ku_q & ~ks_q;
        rneg    = ks_q & ~ku_q;
        cam_cur = cam_q[1];
      end
      2'd2: begin
        fa      = DW'(f2_q);
        ra      = -DW'(sin_y);
        cam_cur = cam_q[2];
      end
      default: begin
        fa = DW'(f0_q);
        ra = DW'(cos_y);
      end
    endcase
    fterm = fpos ? fa : (fneg ? -fa : '0);
    rterm = rpos ? ra : (rneg ? -ra : '0);
    dvec  = fterm + rterm;
  end

  // move along one axis, rounded and saturated
  always_comb begin
    prod_m = PW'(dvec) * $signed({1'b0, move_step_q});
    mv     = (prod_m + M_HALF) >>> SH;
    csum   = MW'(cam_cur) + MW'(mv);
    if (csum > MW'(32'sh7fffffff)) begin
      cam_new = 32'sh7fffffff;
    end else if (csum < MW'(-64'sd2147483648)) begin
      cam_new = 32'sh80000000;
    end else begin
      cam_new = 32'(csum);
    end
  end

  // cursor coordinate, truncated toward zero and saturated
  always_comb begin
    cprod = NW'(fa) * $signed({1'b0, cursor_dist_q});
    nsum  = (NW'(cam_cur) <<< CUR_SH) + cprod;
    qt    = nsum >>> 30;
    if (nsum[NW-1] && (|nsum[29:0])) begin
      qt = qt + NW'(1);
    end
    if (qt > NW'(32767)) begin
      cur_new = 16'sh7fff;
    end else if (qt < NW'(-32768)) begin
      cur_new = 16'sh8000;
    end else begin
      cur_new = 16'(qt);
    end
  end

  // yaw wraps over a full turn, pitch clamps
  always_comb begin
    yv = $signed({4'b0, yaw_q}) - $signed({{2{tx_q[10]}}, tx_q, 6'b0});
    priority if (yv < -19'sd46080) begin
      yofs = 19'sd69120;
    end else if (yv < -19'sd23040) begin
      yofs = 19'sd46080;
    end else if (yv < 19'sd0) begin
      yofs = 19'sd23040;
    end else if (yv < 19'sd23040) begin
      yofs = 19'sd0;
    end else if (yv < 19'sd46080) begin
      yofs = -19'sd23040;
    end else if (yv < 19'sd69120) begin
      yofs = -19'sd46080;
    end else begin
      yofs = -19'sd69120;
    end
    yaw_new = 15'(yv + yofs);
    pv = $signed({{4{pitch_q[13]}}, pitch_q}) + $signed({ty_q[10], ty_q, 6'b0});
    if (pv > 18'(PITCH_LIMIT)) begin
      pitch_new = 14'(PITCH_LIMIT);
    end else if (pv < -18'(PITCH_LIMIT)) begin
      pitch_new = -14'(PITCH_LIMIT);
    end else begin
      pitch_new = 14'(pv);
    end
  end

  // configuration and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_step_q   <= MOVE_STEP_RST;
      cursor_dist_q <= CURSOR_DIST_RST;
      for (int i = 0; i < 3; i++) begin
        cam_q[i] <= '0;
      end
      yaw_q   <= '0;
      pitch_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MOVE_STEP:   move_step_q   <= cfg_data_i;
          CFG_CURSOR_DIST: cursor_dist_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.move) begin
        cam_q[cmd_i.axis] <= cam_new;
      end
      if (cmd_i.rotate) begin
        yaw_q   <= yaw_new;
        pitch_q <= pitch_new;
      end
    end
  end

  // item payload, front terms, cursor and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kf_q <= key_forward_i;
      kb_q <= key_back_i;
      kl_q <= key_left_i;
      kr_q <= key_right_i;
      ku_q <= key_rise_i;
      ks_q <= key_sink_i;
      tx_q <= turn_x_i;
      ty_q <= turn_y_i;
    end
    if (cmd_i.fmul) begin
      if (cmd_i.fsel) begin
        f2_q <= fnew;
      end else begin
        f0_q <= fnew;
      end
    end
    if (cmd_i.cursor) begin
      cur_q[cmd_i.axis] <= cur_new;
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_pos_q[i] <= cam_q[i];
        out_cur_q[i] <= cur_q[i];
      end
      out_yaw_q   <= yaw_q;
      out_pitch_q <= pitch_q;
    end
  end

  assign pos_x_o       = out_pos_q[0];
  assign pos_y_o       = out_pos_q[1];
  assign pos_z_o       = out_pos_q[2];
  assign yaw_angle_o   = out_yaw_q;
  assign pitch_angle_o = out_pitch_q;
  assign cursor_x_o    = out_cur_q[0];
  assign cursor_y_o    = out_cur_q[1];
  assign cursor_z_o    = out_cur_q[2];

endmodule

// File: rtl/fcpu_ctrl.sv
// controller: sequences trig, move, rotation and cursor steps, owns the handshakes
// depends on fcpu_pkg
module fcpu_ctrl import fcpu_pkg::*; #(
  parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output dp_cmd_t                            cmd_o,
  output logic [$clog2(TRIG_ITERATIONS)-1:0] idx_o
);

  localparam int unsigned IW = $clog2(TRIG_ITERATIONS);

  state_e        state_d, state_q;
  logic [IW-1:0] iter_d, iter_q;
  logic [1:0]    axis_d, axis_q;
  logic          phase_d, phase_q;
  logic          out_valid_d, out_valid_q;
  logic          out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and counters
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    axis_d  = axis_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
          phase_d = 1'b0;
        end
      end
      S_PREP: state_d = S_ZMUL;
      S_ZMUL: state_d = S_ZDIV;
      S_ZDIV: begin
        state_d = S_ITER;
        iter_d  = '0;
      end
      S_ITER: begin
        if (iter_q == IW'(TRIG_ITERATIONS - 1)) begin
          state_d = S_FIN;
        end else begin
          iter_d = iter_q + IW'(1);
        end
      end
      S_FIN:   state_d = S_FMUL0;
      S_FMUL0: state_d = S_FMUL2;
      S_FMUL2: begin
        state_d = phase_q ? S_CURSOR : S_MOVE;
        axis_d  = 2'd0;
      end
      S_MOVE: begin
        if (axis_q == 2'd2) begin
          state_d = S_ROTATE;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_ROTATE: begin
        state_d = S_PREP;
        phase_d = 1'b1;
      end
      S_CURSOR: begin
        if (axis_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.top    = TOP_NONE;
    cmd_o.axis   = axis_q;
    unique case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_PREP:   cmd_o.top = TOP_PREP;
      S_ZMUL:   cmd_o.top = TOP_ZMUL;
      S_ZDIV:   cmd_o.top = TOP_ZDIV;
      S_ITER:   cmd_o.top = TOP_ITER;
      S_FIN:    cmd_o.top = TOP_FIN;
      S_FMUL0:  cmd_o.fmul = 1'b1;
      S_FMUL2: begin
        cmd_o.fmul = 1'b1;
        cmd_o.fsel = 1'b1;
      end
      S_MOVE:   cmd_o.move = 1'b1;
      S_ROTATE: cmd_o.rotate = 1'b1;
      S_CURSOR: cmd_o.cursor = 1'b1;
      S_OUT:    cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      axis_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      axis_q      <= axis_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign idx_o       = iter_q;

endmodule

// File: rtl/free_camera_pose_update_top.sv
// free camera pose update: one pose and cursor point per input tick
// Input channel (in_valid_i/in_ready_o) carries six movement keys and two
// pointer deltas in whole degrees. Output channel (out_valid_o/out_ready_i)
// carries the new position (signed fixed point), yaw and pitch in 1/64
// degree, and a cursor point a set number of whole units ahead.
// Configuration is a plain write port: cfg_we_i, cfg_index_i, cfg_data_i;
// index 0 is the move step, index 1 the cursor distance; other indexes
// are ignored.
// Each item runs from transfer in to result valid through two passes of
// the iterative cordic (yaw and pitch in parallel, one rotation per cycle)
// plus three move and three cursor steps on the shared multipliers. The
// next item can be taken in the cycle after the result is loaded; items do
// not overlap, as a new item is taken only once the last result is loaded.
// The result sits in an output register; a stalled receiver holds it while
// the next item is taken and worked on, which then waits for the register
// to free up before loading its own result.
// Reset clears the pose to zero and restores the register defaults.
`include "free_camera_pose_update_top_assert.svh"
module free_camera_pose_update_top import fcpu_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS   = POS_FRAC_BITS_DEF,
  parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 key_forward_i,
  input  logic                 key_back_i,
  input  logic                 key_left_i,
  input  logic                 key_right_i,
  input  logic                 key_rise_i,
  input  logic                 key_sink_i,
  input  logic signed [10:0]   turn_x_i,
  input  logic signed [10:0]   turn_y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   pos_x_o,
  output logic signed [31:0]   pos_y_o,
  output logic signed [31:0]   pos_z_o,
  output logic [14:0]          yaw_angle_o,
  output logic signed [13:0]   pitch_angle_o,
  output logic signed [15:0]   cursor_x_o,
  output logic signed [15:0]   cursor_y_o,
  output logic signed [15:0]   cursor_z_o
);

  dp_cmd_t                            cmd;
  logic [$clog2(TRIG_ITERATIONS)-1:0] idx;

  // sequencer
  fcpu_ctrl #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  // arithmetic and state
  fcpu_datapath #(
    .POS_FRAC_BITS   (POS_FRAC_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .idx_i         (idx),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .key_forward_i (key_forward_i),
    .key_back_i    (key_back_i),
    .key_left_i    (key_left_i),
    .key_right_i   (key_right_i),
    .key_rise_i    (key_rise_i),
    .key_sink_i    (key_sink_i),
    .turn_x_i      (turn_x_i),
    .turn_y_i      (turn_y_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .yaw_angle_o   (yaw_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .cursor_z_o    (cursor_z_o)
  );

  // block goes busy right after an input transfer
  `FCPU_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)
  // a shown yaw is always wrapped into one turn
  `FCPU_ASSERT(a_yaw_wrapped, !out_valid_o || (yaw_angle_o < 15'd23040))
  // a shown pitch is always within the clamp
  `FCPU_ASSERT(a_pitch_clamped, !out_valid_o || (pitch_angle_o <= 14'sd5696 && pitch_angle_o >= -14'sd5696))

endmodule

// File: bench/tb_free_camera_pose_update_top.sv
// testbench for the free camera pose update block: random and directed ticks
// checked against an in-bench pose predictor; depends on fcpu_pkg and the rtl
`timescale 1ns / 1ps
module tb_free_camera_pose_update_top;
  import fcpu_pkg::*;

  typedef struct packed {
    logic [5:0]         keys; // forward, back, left, right, rise, sink
    logic signed [10:0] turn_x;
    logic signed [10:0] turn_y;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [14:0]        yaw;
    logic signed [13:0] pitch;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] cur_z;
  } pose_t;

  localparam int FRAC = 16;
  localparam int ITERS = 16;
  localparam int SETTLE = 80;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic key_forward_i, key_back_i, key_left_i, key_right_i, key_rise_i, key_sink_i;
  logic signed [10:0] turn_x_i, turn_y_i;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [14:0] yaw_angle_o;
  logic signed [13:0] pitch_angle_o;
  logic signed [15:0] cursor_x_o, cursor_y_o, cursor_z_o;

  free_camera_pose_update_top u_top (.*);

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state and settings
  longint cam[3];
  int     cam_yaw, cam_pitch;
  longint step_size;
  longint cursor_dist;
  longint atan_tab[ITERS];

  tick_t  pending_ticks[$];
  pose_t  expected_poses[$];
  int     snd_idle, rcv_idle;
  int     mismatches;
  bit     hold_req, hold_done;
  int     hold_cnt;
  longint cycles;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_lim(longint v, longint lo, longint hi);
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  // cordic sine and cosine of an angle in 1/64 degree
  function automatic void sin_cos(input int a, output longint s, output longint c);
    int q, r;
    longint x, y, z, nx, ny;
    a = a % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    q = a / QUARTER_TURN;
    r = a % QUARTER_TURN;
    z = (longint'(r) * PI_Q30 + 5760) / 11520;
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    case (q)
      0: begin s = y;  c = x;  end
      1: begin s = x;  c = -y; end
      2: begin s = -y; c = -x; end
      default: begin s = -x; c = y; end
    endcase
  endfunction

  function automatic void front_dir(output longint f[3], output longint sy, output longint cy);
    longint sp, cp;
    sin_cos(cam_yaw, sy, cy);
    sin_cos(cam_pitch, sp, cp);
    f[0] = -rnd_shift(cp * sy, 30);
    f[1] = -sp;
    f[2] = -rnd_shift(cp * cy, 30);
  endfunction

  // advance the pose by one tick and queue the resulting pose
  function automatic void predict_pose(tick_t t);
    longint f[3], sy, cy, d[3], fw, rt, up, p, cur[3];
    int yw;
    pose_t e;
    fw = longint'(t.keys[5]) - longint'(t.keys[4]);
    rt = longint'(t.keys[2]) - longint'(t.keys[3]);
    up = longint'(t.keys[1]) - longint'(t.keys[0]);
    front_dir(f, sy, cy);
    d[0] = fw * f[0] + rt * cy;
    d[1] = fw * f[1] + up * ONE_Q30;
    d[2] = fw * f[2] - rt * sy;
    for (int j = 0; j < 3; j++)
      cam[j] = sat_lim(cam[j] + rnd_shift(d[j] * step_size, 46 - FRAC),
                       -64'sd2147483648, 64'sd2147483647);
    // rotation follows the moves
    yw = (cam_yaw - int'(t.turn_x) * 64) % FULL_TURN;
    if (yw < 0) yw += FULL_TURN;
    cam_yaw = yw;
    p = sat_lim(longint'(cam_pitch) + longint'(t.turn_y) * 64, -PITCH_LIMIT, PITCH_LIMIT);
    cam_pitch = int'(p);
    front_dir(f, sy, cy);
    for (int j = 0; j < 3; j++)
      cur[j] = sat_lim((cam[j] * (64'sd1 <<< (30 - FRAC)) + f[j] * cursor_dist) / ONE_Q30,
                       -32768, 32767);
    e.pos_x = 32'(cam[0]);
    e.pos_y = 32'(cam[1]);
    e.pos_z = 32'(cam[2]);
    e.yaw   = 15'(cam_yaw);
    e.pitch = 14'(cam_pitch);
    e.cur_x = 16'(cur[0]);
    e.cur_y = 16'(cur[1]);
    e.cur_z = 16'(cur[2]);
    expected_poses.push_back(e);
  endfunction

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    tick_t t;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {key_forward_i, key_back_i, key_left_i, key_right_i, key_rise_i, key_sink_i} <= '0;
      turn_x_i <= '0;
      turn_y_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o)
        predict_pose({key_forward_i, key_back_i, key_left_i, key_right_i,
                      key_rise_i, key_sink_i, turn_x_i, turn_y_i});
      if (!in_valid_i || in_ready_o) begin
        if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          t = pending_ticks.pop_front();
          in_valid_i <= 1'b1;
          {key_forward_i, key_back_i, key_left_i, key_right_i, key_rise_i, key_sink_i} <= t.keys;
          turn_x_i <= t.turn_x;
          turn_y_i <= t.turn_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off while ticks keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 600) hold_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pos_x_o, pos_y_o, pos_z_o, yaw_angle_o, pitch_angle_o,
             cursor_x_o, cursor_y_o, cursor_z_o};
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose transfer %p", got);
      end else begin
        want = expected_poses.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.pos_z !== want.pos_z || got.yaw !== want.yaw ||
            got.pitch !== want.pitch || got.cur_x !== want.cur_x ||
            got.cur_y !== want.cur_y || got.cur_z !== want.cur_z) begin
          mismatches++;
          if (mismatches <= 10) $display("pose mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_ticks.size() > 0 || in_valid_i || expected_poses.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_MOVE_STEP) step_size = val;
    else if (idx == CFG_CURSOR_DIST) cursor_dist = val[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.keys = 6'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      t.turn_x = $signed(11'($urandom_range(0, 40))) - 11'sd20;
      t.turn_y = $signed(11'($urandom_range(0, 20))) - 11'sd10;
    end else begin
      t.turn_x = 11'($urandom);
      t.turn_y = 11'($urandom);
    end
    return t;
  endfunction

  task automatic add_ticks(int n);
    for (int i = 0; i < n; i++) pending_ticks.push_back(rand_tick());
  endtask

  initial begin
    longint sum, tm;
    int ex;
    // arctangent table, truncated alternating series
    atan_tab[0] = PI_Q30 / 4;
    for (int i = 1; i < ITERS; i++) begin
      sum = 0;
      for (int k = 0; k < 32; k++) begin
        ex = 30 - i * (2 * k + 1);
        if (ex >= 0) begin
          tm = (64'sd1 <<< ex) / (2 * k + 1);
          sum = (k % 2) ? sum - tm : sum + tm;
        end
      end
      atan_tab[i] = sum;
    end
    cam = '{0, 0, 0};
    cam_yaw = 0;
    cam_pitch = 0;
    step_size = MOVE_STEP_RST;
    cursor_dist = CURSOR_DIST_RST;
    mismatches = 0;
    cycles = 0;
    hold_req = 1'b0;
    snd_idle = 30;
    rcv_idle = 68;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MOVE_STEP;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single keys, opposite pairs, turn extremes and pitch clamp
    for (int b = 0; b < 6; b++) pending_ticks.push_back('{6'(1 << b), 11'sd0, 11'sd0});
    pending_ticks.push_back('{6'b110000, 11'sd0, 11'sd0});
    pending_ticks.push_back('{6'b001100, 11'sd0, 11'sd0});
    pending_ticks.push_back('{6'b000011, 11'sd0, 11'sd0});
    pending_ticks.push_back('{6'b111111, 11'sd0, 11'sd0});
    pending_ticks.push_back('{6'b101010, 11'sh400, 11'sd1023});
    pending_ticks.push_back('{6'b100100, 11'sd1023, 11'sd1023});
    pending_ticks.push_back('{6'b100001, 11'sd90, 11'sh400});
    pending_ticks.push_back('{6'b010010, -11'sd90, 11'sd89});
    pending_ticks.push_back('{6'b100000, 11'sd359, 11'sd1});
    pending_ticks.push_back('{6'b100000, 11'sd1, -11'sd1});
    pending_ticks.push_back('{6'b000000, 11'sd0, 11'sd0});
    wait_idle();

    // extremes of both registers, plus writes to unused indexes
    write_reg(CFG_MOVE_STEP, 16'hFFFF);
    write_reg(CFG_CURSOR_DIST, 16'hFFFF);
    write_reg(2'd2, 16'h0001);
    write_reg(2'd3, 16'h0000);
    add_ticks(650);
    repeat (200) @(posedge clk_i);
    hold_req = 1'b1;
    wait_idle();

    write_reg(CFG_MOVE_STEP, 16'h0000);
    write_reg(CFG_CURSOR_DIST, 16'h0000);
    snd_idle = 68;
    rcv_idle = 30;
    add_ticks(300);
    wait_idle();

    write_reg(CFG_MOVE_STEP, 16'($urandom));
    write_reg(CFG_CURSOR_DIST, 16'($urandom));
    snd_idle = 0;
    rcv_idle = 0;
    add_ticks(500);
    wait_idle();

    write_reg(CFG_MOVE_STEP, 16'd6554);
    write_reg(CFG_CURSOR_DIST, 16'd200);
    add_ticks(430);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: free_camera_pose_update_top.f
+incdir+rtl
rtl/fcpu_pkg.sv
rtl/fcpu_cordic.sv
rtl/fcpu_datapath.sv
rtl/fcpu_ctrl.sv
rtl/free_camera_pose_update_top.sv
bench/tb_free_camera_pose_update_top.sv
